// ----- hw/rtl/atpb_pkg.sv -----
// Shared types and constants for the alpha/tint pixel blender.
// No dependencies; every other file in hw/rtl imports this package.
package atpb_pkg;

  localparam int NUM_LANES  = 3;                    // red, green, blue
  localparam int CHAN_W     = 8;
  localparam int IN_DATA_W  = 11 * CHAN_W;          // 3 dst + 4 src + 4 tint channels
  localparam int OUT_DATA_W = NUM_LANES * CHAN_W;
  localparam int SRC_A_LSB  = 2 * NUM_LANES * CHAN_W;
  localparam int TINT_LSB   = SRC_A_LSB + CHAN_W;
  localparam int TINT_A_LSB = TINT_LSB + NUM_LANES * CHAN_W;

  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hff;
  localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'h00;

  typedef enum logic [0:0] {
    CMD_FILL = 1'b0,
    CMD_TINT = 1'b1
  } cmd_t;

  typedef logic [CHAN_W-1:0] chan_t;

  // Per-request control that travels with the lane data.
  typedef struct packed {
    cmd_t cmd;
    logic we;    // pixel is written
    logic pass;  // opaque fill: source passes through
  } ctrl_t;

endpackage

// ----- hw/rtl/alpha_tint_pixel_blender_unit.sv -----
// Top level of the alpha/tint pixel blender: input stage, alpha stage, lanes, merge.
// Depends on atpb_pkg, atpb_lane and atpb_merge.
//
// channel | dir | tdata (low bit up)                                      | tuser
// s_*     | in  | dst r,g,b, src r,g,b,a, tint r,g,b,a (8 bits each)      | cmd
// m_*     | out | out r,g,b (8 bits each)                                 | write_enable
//
// One pixel per clock while the output is not stalled; stages: input register, multiply stage, output register.
// Each lane splits its products over two stages: an 8x8 texel-by-tint product, then a
// 16x8 and an 8x8 alpha product.
// rst clears the stage valid bits only; data registers carry no reset.
// A stalled output holds its result; earlier stages keep filling until all are full.
module alpha_tint_pixel_blender_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [atpb_pkg::IN_DATA_W-1:0]    s_tdata,   // dst r,g,b, src r,g,b,a, tint r,g,b,a
  input  logic                              s_tuser,   // cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [atpb_pkg::OUT_DATA_W-1:0]   m_tdata,   // out r,g,b
  output logic                              m_tuser    // write_enable
);
  import atpb_pkg::*;

  logic                             a_valid;
  logic                             b_valid;
  logic                             adv_a;
  logic                             adv_b;
  logic                             adv_c;
  cmd_t                             cmd_a;
  logic [IN_DATA_W-1:0]             data_a;
  chan_t                            sa_a;
  chan_t                            ta_a;
  logic [2*CHAN_W-1:0]              alpha_prod;
  chan_t                            alpha_next;
  ctrl_t                            ctrl_next;
  chan_t                            alpha_b;
  ctrl_t                            ctrl_b;
  logic [NUM_LANES-1:0][CHAN_W-1:0] lane_res;

  assign adv_c    = !m_tvalid || m_tready;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign s_tready = adv_a;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      cmd_a  <= cmd_t'(s_tuser);
      data_a <= s_tdata;
    end
  end

  assign sa_a       = data_a[SRC_A_LSB +: CHAN_W];
  assign ta_a       = data_a[TINT_A_LSB +: CHAN_W];
  assign alpha_prod = sa_a * ta_a;

  always_comb begin
    unique case (cmd_a)
      CMD_FILL: begin
        alpha_next     = sa_a;
        ctrl_next.we   = (sa_a != ALPHA_ZERO);
        ctrl_next.pass = (sa_a == ALPHA_FULL);
      end
      CMD_TINT: begin
        alpha_next     = alpha_prod[2*CHAN_W-1:CHAN_W];
        ctrl_next.we   = (ta_a != ALPHA_ZERO);
        ctrl_next.pass = 1'b0;
      end
      default: begin
        alpha_next     = sa_a;
        ctrl_next.we   = 1'b0;
        ctrl_next.pass = 1'b0;
      end
    endcase
    ctrl_next.cmd = cmd_a;
  end

  // Alpha stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      alpha_b <= alpha_next;
      ctrl_b  <= ctrl_next;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    atpb_lane u_lane (
      .clk     (clk),
      .adv_b   (adv_b),
      .cmd_a   (cmd_a),
      .src_a   (data_a[NUM_LANES*CHAN_W + i*CHAN_W +: CHAN_W]),
      .tint_a  (data_a[TINT_LSB + i*CHAN_W +: CHAN_W]),
      .dst_a   (data_a[i*CHAN_W +: CHAN_W]),
      .alpha_b (alpha_b),
      .ctrl_b  (ctrl_b),
      .res     (lane_res[i])
    );
  end

  atpb_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .adv_c    (adv_c),
    .b_valid  (b_valid),
    .ctrl_b   (ctrl_b),
    .lane_res (lane_res),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A suppressed pixel leaves with black color.
  a_zero_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("suppressed pixel carries color");

  // A blocked input stage keeps its request.
  a_hold_a: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv_b |=> a_valid && $stable(data_a))
    else $error("input stage lost a request");

  // A blocked alpha stage keeps its request.
  a_hold_b: assert property (@(posedge clk) disable iff (rst)
    b_valid && !adv_c |=> b_valid && $stable(alpha_b) && $stable(ctrl_b))
    else $error("alpha stage lost a request");

  // Pass-through only for written fill pixels.
  a_pass_fill: assert property (@(posedge clk) disable iff (rst)
    b_valid && ctrl_b.pass |-> ctrl_b.we && ctrl_b.cmd == CMD_FILL && alpha_b == ALPHA_FULL)
    else $error("pass-through on a non-opaque fill");

endmodule

// ----- hw/rtl/atpb_lane.sv -----
// One color channel of the blender: two-stage multiply datapath.
// Depends on atpb_pkg.
module atpb_lane (
  input  logic            clk,
  input  logic            adv_b,
  input  atpb_pkg::cmd_t  cmd_a,
  input  atpb_pkg::chan_t src_a,
  input  atpb_pkg::chan_t tint_a,
  input  atpb_pkg::chan_t dst_a,
  input  atpb_pkg::chan_t alpha_b,
  input  atpb_pkg::ctrl_t ctrl_b,
  output atpb_pkg::chan_t res
);
  import atpb_pkg::*;

  logic [2*CHAN_W-1:0] mod_b;
  logic [2*CHAN_W-1:0] mod_next;
  chan_t               dst_b;
  logic [3*CHAN_W-1:0] src_term;
  logic [2*CHAN_W-1:0] dst_term;
  logic [2*CHAN_W:0]   fill_sum;
  chan_t               tint_sum;

  // Tinted mode modulates texel by tint; fill mode carries the source as is.
  assign mod_next = (cmd_a == CMD_TINT) ? src_a * tint_a : {{CHAN_W{1'b0}}, src_a};

  always_ff @(posedge clk) begin
    if (adv_b) begin
      mod_b <= mod_next;
      dst_b <= dst_a;
    end
  end

  assign src_term = mod_b * alpha_b;
  assign dst_term = dst_b * (ALPHA_FULL - alpha_b);
  assign fill_sum = {1'b0, src_term[2*CHAN_W-1:0]} + {1'b0, dst_term};
  assign tint_sum = src_term[3*CHAN_W-1:2*CHAN_W] + dst_term[2*CHAN_W-1:CHAN_W];

  always_comb begin
    if (ctrl_b.pass) begin
      res = mod_b[CHAN_W-1:0];
    end else if (ctrl_b.cmd == CMD_TINT) begin
      res = tint_sum;
    end else begin
      res = fill_sum[2*CHAN_W-1:CHAN_W];
    end
  end

endmodule

// ----- hw/rtl/atpb_merge.sv -----
// Output stage: merges the lane results into one result register.
// Depends on atpb_pkg.
module atpb_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          adv_c,
  input  logic                                          b_valid,
  input  atpb_pkg::ctrl_t                               ctrl_b,
  input  logic [atpb_pkg::NUM_LANES-1:0][atpb_pkg::CHAN_W-1:0] lane_res,
  output logic                                          m_tvalid,
  output logic [atpb_pkg::OUT_DATA_W-1:0]               m_tdata,
  output logic                                          m_tuser
);
  import atpb_pkg::*;

  logic [OUT_DATA_W-1:0] data_next;

  // Drop the color of a suppressed pixel.
  assign data_next = ctrl_b.we ? OUT_DATA_W'(lane_res) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_c) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      m_tdata <= data_next;
      m_tuser <= ctrl_b.we;
    end
  end

endmodule

// ----- bench/pixel_blend_checker.sv -----
// Scoreboard for the alpha/tint pixel blender: predicts each accepted request and
// compares it with the next output beat. Depends on atpb_pkg only.
module pixel_blend_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [atpb_pkg::IN_DATA_W-1:0]  s_tdata,   // dst r,g,b, src r,g,b,a, tint r,g,b,a
  input  logic                            s_tuser,   // cmd
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [atpb_pkg::OUT_DATA_W-1:0] m_tdata,   // out r,g,b
  input  logic                            m_tuser,   // write_enable
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import atpb_pkg::*;

  // Same bit order as {m_tuser, m_tdata}.
  typedef struct packed {
    logic  we;
    chan_t blue;
    chan_t green;
    chan_t red;
  } blend_t;

  blend_t blend_queue[$];
  blend_t got_px;
  blend_t want_px;

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic blend_t predict_pixel(input cmd_t cmd, input logic [IN_DATA_W-1:0] px);
    logic [31:0] src_a;
    logic [31:0] tint_a;
    logic [31:0] eff_a;
    logic [31:0] acc;
    logic [31:0] dst_c;
    logic [31:0] src_c;
    logic [31:0] tint_c;
    chan_t       lane[NUM_LANES];
    blend_t      res;
    int          i;
    src_a  = 32'(px[SRC_A_LSB +: CHAN_W]);
    tint_a = 32'(px[TINT_A_LSB +: CHAN_W]);
    res    = '0;
    for (i = 0; i < NUM_LANES; i++) lane[i] = '0;
    if (cmd == CMD_FILL) begin
      if (src_a != ALPHA_ZERO) begin
        res.we = 1'b1;
        for (i = 0; i < NUM_LANES; i++) begin
          dst_c = 32'(px[i*CHAN_W +: CHAN_W]);
          src_c = 32'(px[(NUM_LANES+i)*CHAN_W +: CHAN_W]);
          if (src_a == ALPHA_FULL) begin
            lane[i] = src_c[CHAN_W-1:0];
          end else begin
            acc     = (src_c * src_a + dst_c * (ALPHA_FULL - src_a)) >> 8;
            lane[i] = acc[CHAN_W-1:0];
          end
        end
      end
    end else if (tint_a != ALPHA_ZERO) begin
      eff_a  = ((src_a * tint_a) >> 8) & 32'hff;
      res.we = 1'b1;
      for (i = 0; i < NUM_LANES; i++) begin
        dst_c   = 32'(px[i*CHAN_W +: CHAN_W]);
        src_c   = 32'(px[(NUM_LANES+i)*CHAN_W +: CHAN_W]);
        tint_c  = 32'(px[TINT_LSB + i*CHAN_W +: CHAN_W]);
        acc     = ((src_c * tint_c * eff_a) >> 16) + ((dst_c * (ALPHA_FULL - eff_a)) >> 8);
        lane[i] = acc[CHAN_W-1:0];
      end
    end
    res.red   = lane[0];
    res.green = lane[1];
    res.blue  = lane[2];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Retire first so an output with nothing queued is never masked by a new request.
      if (m_tvalid && m_tready) begin
        got_px = {m_tuser, m_tdata};
        if (blend_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected output: r=%0h g=%0h b=%0h we=%b",
                                  got_px.red, got_px.green, got_px.blue, got_px.we));
        end else begin
          want_px = blend_queue.pop_front();
          if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
              got_px.blue !== want_px.blue || got_px.we !== want_px.we)
            flag_mismatch($sformatf(
              "pixel differs: expected r=%0h g=%0h b=%0h we=%b, got r=%0h g=%0h b=%0h we=%b",
              want_px.red, want_px.green, want_px.blue, want_px.we,
              got_px.red, got_px.green, got_px.blue, got_px.we));
        end
      end
      if (s_tvalid && s_tready)
        blend_queue.push_back(predict_pixel(cmd_t'(s_tuser), s_tdata));
    end
    outstanding <= blend_queue.size();
  end

endmodule

// ----- bench/tb.sv -----
// Top of the pixel blender bench: clock, reset, request stream and output back-pressure.
// Depends on atpb_pkg, alpha_tint_pixel_blender_unit and pixel_blend_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atpb_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // dst r,g,b, src r,g,b,a, tint r,g,b,a
  logic                  s_tuser  = 1'b0; // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // out r,g,b
  logic                  m_tuser;         // write_enable
  int                    mismatches;
  int                    outstanding;

  alpha_tint_pixel_blender_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pixel_blend_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("alpha_tint_pixel_blender_unit: mismatch");
    $finish;
  end

  // Mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Lean on the ends of the range, where the blend math saturates or vanishes.
  function automatic chan_t pick_level();
    unique case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return chan_t'($urandom_range(1, 3));
      3:       return chan_t'($urandom_range(252, 254));
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_pixel(
    input chan_t dst_r, input chan_t dst_g, input chan_t dst_b,
    input chan_t src_r, input chan_t src_g, input chan_t src_b, input chan_t src_a,
    input chan_t tint_r, input chan_t tint_g, input chan_t tint_b, input chan_t tint_a);
    return {tint_a, tint_b, tint_g, tint_r, src_a, src_b, src_g, src_r, dst_b, dst_g, dst_r};
  endfunction

  // Entered and left at a falling edge; valid stays high into the next request.
  task automatic send_pixel(input cmd_t cmd, input logic [IN_DATA_W-1:0] px, input int gap);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Output back-pressure: bursts of stalls, with long stretches of steady ready.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(100, 300)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
        m_tready <= 1'b0;
        repeat (1 + pick_gap()) @(negedge clk);
      end
    end
  end

  initial begin
    cmd_t cmd;
    int   gap;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero fill alpha, opaque fill, alpha ends, unused tint.
    send_pixel(CMD_FILL, pack_pixel(10, 20, 30, 200, 150, 100, 0, 1, 2, 3, 255), 0);
    send_pixel(CMD_FILL, pack_pixel(10, 20, 30, 200, 150, 100, 255, 1, 2, 3, 0), 0);
    send_pixel(CMD_FILL, pack_pixel(255, 255, 255, 0, 0, 0, 1, 0, 0, 0, 0), 0);
    send_pixel(CMD_FILL, pack_pixel(0, 0, 0, 255, 255, 255, 254, 0, 0, 0, 0), pick_gap());
    send_pixel(CMD_FILL, pack_pixel(255, 255, 255, 255, 255, 255, 128, 9, 9, 9, 9), pick_gap());
    send_pixel(CMD_FILL, pack_pixel(0, 0, 0, 0, 0, 0, 128, 255, 255, 255, 0), pick_gap());
    send_pixel(CMD_FILL, pack_pixel(8'h55, 8'h55, 8'h55, 8'haa, 8'haa, 8'haa, 8'h80,
                                    8'haa, 8'h55, 8'haa, 8'h55), pick_gap());
    send_pixel(CMD_FILL, pack_pixel(8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'h55,
                                    8'h55, 8'haa, 8'h55, 8'haa), pick_gap());
    // Zero tint alpha, zero texel alpha, full and minimal tint.
    send_pixel(CMD_TINT, pack_pixel(50, 60, 70, 255, 255, 255, 255, 255, 255, 255, 0), 0);
    send_pixel(CMD_TINT, pack_pixel(50, 60, 70, 255, 255, 255, 0, 255, 255, 255, 255), 0);
    send_pixel(CMD_TINT, pack_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255), 0);
    send_pixel(CMD_TINT, pack_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), pick_gap());
    send_pixel(CMD_TINT, pack_pixel(0, 0, 0, 255, 255, 255, 255, 255, 255, 255, 1), pick_gap());
    send_pixel(CMD_TINT, pack_pixel(255, 255, 255, 0, 0, 0, 1, 0, 0, 0, 255), pick_gap());
    send_pixel(CMD_TINT, pack_pixel(8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'haa,
                                    8'h55, 8'h55, 8'h55, 8'haa), pick_gap());
    send_pixel(CMD_TINT, pack_pixel(8'h55, 8'h55, 8'h55, 8'haa, 8'haa, 8'haa, 8'h55,
                                    8'haa, 8'haa, 8'haa, 8'h55), pick_gap());
    send_pixel(CMD_TINT, pack_pixel(255, 0, 128, 0, 255, 128, 200, 255, 128, 0, 200), 0);
    drain_results();

    for (int i = 0; i < 1500; i++) begin
      cmd = $urandom_range(0, 1) ? CMD_TINT : CMD_FILL;
      // Every fourth block of a hundred runs back to back.
      gap = ((i / 100) % 4 == 3) ? 0 : pick_gap();
      send_pixel(cmd, pack_pixel(pick_level(), pick_level(), pick_level(),
                                 pick_level(), pick_level(), pick_level(), pick_level(),
                                 pick_level(), pick_level(), pick_level(), pick_level()), gap);
      if (i == 750) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("alpha_tint_pixel_blender_unit: match");
    end else begin
      $display("alpha_tint_pixel_blender_unit: mismatch");
    end
    $finish;
  end

endmodule
